// ===== rtl/core/wapc_pkg.sv =====
// Package with the payload types and the shared codes of the wake alarm pair controller.
package wapc_pkg;

  // Kinds of input item.
  localparam logic [2:0] KIND_TICK        = 3'd0;
  localparam logic [2:0] KIND_SKIP_DAILY  = 3'd1;
  localparam logic [2:0] KIND_STOP_DAILY  = 3'd2;
  localparam logic [2:0] KIND_SKIP_SINGLE = 3'd3;
  localparam logic [2:0] KIND_STOP_SINGLE = 3'd4;
  localparam logic [2:0] KIND_SET_ARMED   = 3'd5;

  // Alarm phases, as reported in the status fields.
  localparam logic [1:0] PH_STANDBY = 2'd0;
  localparam logic [1:0] PH_PRE     = 2'd1;
  localparam logic [1:0] PH_ALARM   = 2'd2;
  localparam logic [1:0] PH_SKIP    = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_DAILY_ENABLE  = 3'd0;
  localparam logic [2:0] REG_DAILY_HOUR    = 3'd1;
  localparam logic [2:0] REG_DAILY_MINUTE  = 3'd2;
  localparam logic [2:0] REG_SINGLE_HOUR   = 3'd3;
  localparam logic [2:0] REG_SINGLE_MINUTE = 3'd4;
  localparam logic [2:0] REG_PREALARM_SEC  = 3'd5;
  localparam logic [2:0] REG_RAMP_SEC      = 3'd6;

  localparam int unsigned CFG_DATA_W = 16;

  // Reset values of the window and ramp lengths.
  localparam logic [15:0] PREALARM_SEC_RST = 16'd1800;
  localparam logic [11:0] RAMP_SEC_RST     = 12'd300;

  // Level that stands for 1.0.
  localparam logic [8:0] FULL_LEVEL = 9'd256;

  typedef struct packed {
    logic [2:0]  kind;
    logic [16:0] time_of_day;
    logic        armed_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] daily_status;
    logic [1:0] single_status;
    logic       single_armed;
    logic [8:0] daily_pre_level;
    logic [8:0] daily_ramp_level;
    logic [8:0] single_pre_level;
    logic [8:0] single_ramp_level;
  } out_item_t;

endpackage

// ===== rtl/core/wake_alarm_pair_controller.sv =====
// Top level of the wake alarm pair controller: phase update and shared level divider.
//
//   Channel  Direction  Handshake                Payload
//   in_      input      in_valid / in_stall      wapc_pkg::in_item_t (kind, time, armed)
//   out_     output     out_valid / out_stall    wapc_pkg::out_item_t (states, levels)
//   cfg_     input      cfg_we (write only)      cfg_index, cfg_wdata
//
// The phases are updated at the edge of the input transfer itself. Each alarm then
// takes a setup step, plus a run of the shared restoring divider when its level
// needs a division, and a finish step loads the output register. The input stays
// stalled from the transfer until the finish step is done, so a new item is taken
// only once the last one has reached the output register.
// Reset is synchronous and active low; it clears the phases, the armed flag, the
// last time and the configuration to their reset values. A stalled result holds
// in the output register while the next item is already taken and worked on; that
// item's result waits in the finish cycle until the register is free.
module wake_alarm_pair_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  wapc_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output wapc_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [wapc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import wapc_pkg::*;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SETUP  = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  // The divider produces one quotient bit per step, nine bits in all.
  localparam logic [3:0] DIV_LAST = 4'd8;

  // What one alarm needs from the divider: either a fixed level or a division.
  typedef struct packed {
    logic        need_div;
    logic [8:0]  fixed_level;
    logic [16:0] num;
    logic [15:0] den;
  } prep_t;

  // Configuration registers.
  logic        daily_enable_r;
  logic [4:0]  daily_hour_r;
  logic [5:0]  daily_minute_r;
  logic [4:0]  single_hour_r;
  logic [5:0]  single_minute_r;
  logic [15:0] prealarm_sec_r;
  logic [11:0] ramp_sec_r;

  // Alarm state.
  logic [1:0]  daily_phase_r, daily_phase_nxt;
  logic [1:0]  single_phase_r, single_phase_nxt;
  logic        single_arm_r, single_arm_nxt;
  logic [16:0] last_time_r, last_time_nxt;

  // Sequencer and divider.
  logic [1:0]  state_r, state_nxt;
  logic        sel_r, sel_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] den_r, den_nxt;
  logic [8:0]  quo_r, quo_nxt;
  logic [8:0]  daily_level_r, daily_level_nxt;
  logic [8:0]  single_level_r, single_level_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic        in_acc;
  logic [16:0] a_daily, a_single;
  logic [16:0] a_sel;
  logic [1:0]  phase_sel;
  prep_t       prep;
  logic [16:0] trial;
  logic        ge;
  logic [16:0] trial_sub;
  logic [8:0]  level_done;

  // Alarm time in seconds; for any hour and minute code it fits in 17 bits.
  function automatic logic [16:0] alarm_time(input logic [4:0] hour, input logic [5:0] minute);
    logic [16:0] h_sec;
    logic [16:0] m_sec;
    h_sec = {12'd0, hour} * 17'd3600;
    m_sec = {11'd0, minute} * 17'd60;
    return h_sec + m_sec;
  endfunction

  // Phase step on a tick, checked in order of priority.
  function automatic logic [1:0] advance(input logic [1:0] phase, input logic active,
                                         input logic skip_rearms, input logic [16:0] t,
                                         input logic [16:0] a, input logic [15:0] p);
    logic [17:0] t_plus_p;
    logic [1:0]  res;
    t_plus_p = {1'b0, t} + {2'b00, p};
    if (!active) begin
      res = PH_STANDBY;
    end else if (phase == PH_ALARM) begin
      res = PH_ALARM;
    end else if (phase == PH_PRE && t >= a) begin
      res = PH_ALARM;
    end else if (skip_rearms && phase == PH_SKIP && t >= a) begin
      res = PH_STANDBY;
    end else if (phase != PH_SKIP && t < a && t_plus_p >= {1'b0, a}) begin
      res = PH_PRE;
    end else begin
      res = phase;
    end
    return res;
  endfunction

  assign a_daily  = alarm_time(daily_hour_r, daily_minute_r);
  assign a_single = alarm_time(single_hour_r, single_minute_r);

  // The input is ready whenever the sequencer is idle; a waiting result does not
  // hold it back, since the output register keeps that result apart.
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      daily_enable_r  <= 1'b0;
      daily_hour_r    <= '0;
      daily_minute_r  <= '0;
      single_hour_r   <= '0;
      single_minute_r <= '0;
      prealarm_sec_r  <= PREALARM_SEC_RST;
      ramp_sec_r      <= RAMP_SEC_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DAILY_ENABLE:  daily_enable_r  <= cfg_wdata[0];
        REG_DAILY_HOUR:    daily_hour_r    <= cfg_wdata[4:0];
        REG_DAILY_MINUTE:  daily_minute_r  <= cfg_wdata[5:0];
        REG_SINGLE_HOUR:   single_hour_r   <= cfg_wdata[4:0];
        REG_SINGLE_MINUTE: single_minute_r <= cfg_wdata[5:0];
        REG_PREALARM_SEC:  prealarm_sec_r  <= cfg_wdata[15:0];
        REG_RAMP_SEC:      ramp_sec_r      <= cfg_wdata[11:0];
        default: begin
        end
      endcase
    end
  end

  // Phase update in the transfer cycle. Commands never apply the tick rules.
  always_comb begin
    daily_phase_nxt  = daily_phase_r;
    single_phase_nxt = single_phase_r;
    single_arm_nxt   = single_arm_r;
    last_time_nxt    = last_time_r;
    if (in_acc) begin
      unique case (in_data.kind)
        KIND_TICK: begin
          last_time_nxt    = in_data.time_of_day;
          daily_phase_nxt  = advance(daily_phase_r, daily_enable_r, 1'b1,
                                     in_data.time_of_day, a_daily, prealarm_sec_r);
          single_phase_nxt = advance(single_phase_r, single_arm_r, 1'b0,
                                     in_data.time_of_day, a_single, prealarm_sec_r);
        end
        KIND_SKIP_DAILY:  daily_phase_nxt = PH_SKIP;
        KIND_STOP_DAILY:  daily_phase_nxt = PH_STANDBY;
        KIND_SKIP_SINGLE: single_phase_nxt = PH_SKIP;
        KIND_STOP_SINGLE: begin
          single_phase_nxt = PH_STANDBY;
          single_arm_nxt   = 1'b0;
        end
        KIND_SET_ARMED:   single_arm_nxt = in_data.armed_value;
        default: begin
        end
      endcase
    end
  end

  // Setup for the selected alarm. In pre-alarm the level is the elapsed part of
  // the window over the window; in alarm it is the time past the alarm over the
  // ramp length. The edge cases give a fixed level and skip the divider.
  assign a_sel     = sel_r ? a_single : a_daily;
  assign phase_sel = sel_r ? single_phase_r : daily_phase_r;

  always_comb begin
    logic [16:0] left;
    logic [17:0] a_plus_r;
    left     = a_sel - last_time_r;
    a_plus_r = {1'b0, a_sel} + {6'd0, ramp_sec_r};
    prep.need_div    = 1'b0;
    prep.fixed_level = '0;
    prep.num         = '0;
    prep.den         = '0;
    if (phase_sel == PH_PRE) begin
      if (prealarm_sec_r == '0 || last_time_r >= a_sel) begin
        prep.fixed_level = FULL_LEVEL;
      end else if (left >= {1'b0, prealarm_sec_r}) begin
        prep.fixed_level = '0;
      end else begin
        prep.need_div = 1'b1;
        prep.num      = {1'b0, prealarm_sec_r - left[15:0]};
        prep.den      = prealarm_sec_r;
      end
    end else if (phase_sel == PH_ALARM) begin
      if (ramp_sec_r == '0 || {1'b0, last_time_r} > a_plus_r) begin
        prep.fixed_level = FULL_LEVEL;
      end else if (last_time_r < a_sel) begin
        prep.fixed_level = '0;
      end else begin
        prep.need_div = 1'b1;
        prep.num      = last_time_r - a_sel;
        prep.den      = {4'd0, ramp_sec_r};
      end
    end
  end

  // Restoring divider step. The numerator never exceeds the divisor, so the
  // first step needs no shift and yields the bit worth 256; the remainder then
  // stays below the divisor and its doubled value fits in 17 bits.
  assign trial      = (cnt_r == '0) ? rem_r : {rem_r[15:0], 1'b0};
  assign ge         = (trial >= {1'b0, den_r});
  assign trial_sub  = trial - {1'b0, den_r};
  assign level_done = {quo_r[7:0], ge};

  // Sequencer.
  always_comb begin
    state_nxt        = state_r;
    sel_nxt          = sel_r;
    cnt_nxt          = cnt_r;
    rem_nxt          = rem_r;
    den_nxt          = den_r;
    quo_nxt          = quo_r;
    daily_level_nxt  = daily_level_r;
    single_level_nxt = single_level_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_data_nxt     = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SETUP;
          sel_nxt   = 1'b0;
        end
      end
      ST_SETUP: begin
        if (prep.need_div) begin
          rem_nxt   = prep.num;
          den_nxt   = prep.den;
          quo_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end else begin
          if (sel_r) begin
            single_level_nxt = prep.fixed_level;
            state_nxt        = ST_FINISH;
          end else begin
            daily_level_nxt = prep.fixed_level;
            sel_nxt         = 1'b1;
          end
        end
      end
      ST_DIV: begin
        rem_nxt = ge ? trial_sub : trial;
        quo_nxt = level_done;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == DIV_LAST) begin
          if (sel_r) begin
            single_level_nxt = level_done;
            state_nxt        = ST_FINISH;
          end else begin
            daily_level_nxt = level_done;
            sel_nxt         = 1'b1;
            state_nxt       = ST_SETUP;
          end
        end
      end
      ST_FINISH: begin
        // Load the output register once it is empty or being emptied.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                  = 1'b1;
          out_data_nxt.daily_status      = daily_phase_r;
          out_data_nxt.single_status     = single_phase_r;
          out_data_nxt.single_armed      = single_arm_r;
          out_data_nxt.daily_pre_level   = (daily_phase_r == PH_PRE) ? daily_level_r : '0;
          out_data_nxt.daily_ramp_level  = (daily_phase_r == PH_ALARM) ? daily_level_r : '0;
          out_data_nxt.single_pre_level  = (single_phase_r == PH_PRE) ? single_level_r : '0;
          out_data_nxt.single_ramp_level = (single_phase_r == PH_ALARM) ? single_level_r : '0;
          state_nxt                      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      sel_r          <= 1'b0;
      cnt_r          <= '0;
      out_valid_r    <= 1'b0;
      daily_phase_r  <= PH_STANDBY;
      single_phase_r <= PH_STANDBY;
      single_arm_r   <= 1'b0;
      last_time_r    <= '0;
    end else begin
      state_r        <= state_nxt;
      sel_r          <= sel_nxt;
      cnt_r          <= cnt_nxt;
      out_valid_r    <= out_valid_nxt;
      daily_phase_r  <= daily_phase_nxt;
      single_phase_r <= single_phase_nxt;
      single_arm_r   <= single_arm_nxt;
      last_time_r    <= last_time_nxt;
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    rem_r          <= rem_nxt;
    den_r          <= den_nxt;
    quo_r          <= quo_nxt;
    daily_level_r  <= daily_level_nxt;
    single_level_r <= single_level_nxt;
    out_data_r     <= out_data_nxt;
  end

endmodule

// ===== rtl/core/wapc_checker.sv =====
// Port-level checker for the wake alarm pair controller, with its bind statement.
module wapc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input wapc_pkg::out_item_t             out_data
);
  import wapc_pkg::*;

  // An accepted item keeps the block busy for at least the next cycle.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input ready right after a transfer");

  // A stalled result stays and holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Pre-alarm levels only appear in pre-alarm and never exceed full scale.
  a_pre_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.daily_pre_level == '0 || out_data.daily_status == PH_PRE) &&
                  (out_data.single_pre_level == '0 || out_data.single_status == PH_PRE) &&
                  out_data.daily_pre_level <= FULL_LEVEL &&
                  out_data.single_pre_level <= FULL_LEVEL)
    else $error("pre-alarm level outside pre-alarm or above full scale");

  // Ramp levels only appear while alarming and never exceed full scale.
  a_ramp_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.daily_ramp_level == '0 || out_data.daily_status == PH_ALARM) &&
                  (out_data.single_ramp_level == '0 || out_data.single_status == PH_ALARM) &&
                  out_data.daily_ramp_level <= FULL_LEVEL &&
                  out_data.single_ramp_level <= FULL_LEVEL)
    else $error("ramp level outside alarm or above full scale");

endmodule

bind wake_alarm_pair_controller wapc_checker u_wapc_checker (.*);
